/* sv/cta_pkg.sv */
// Package for the calendar timestamp advance unit.
// Holds the item structs, field widths, carry limits and the month-length check.
// Used by cta_clock, cta_date and calendar_timestamp_advance_unit.
package cta_pkg;

  // Field widths of the timestamp.
  localparam int unsigned YEAR_WIDTH_DEF   = 12;
  localparam int unsigned YEAR_FIELD_WIDTH = 12;
  localparam int unsigned MONTH_WIDTH      = 4;
  localparam int unsigned DAY_WIDTH        = 5;
  localparam int unsigned HOUR_WIDTH       = 5;
  localparam int unsigned MIN_WIDTH        = 6;
  localparam int unsigned SEC_WIDTH        = 6;
  localparam int unsigned MS_WIDTH         = 10;

  // Carry limits, one bit wider than the field they apply to.
  localparam logic [MS_WIDTH:0]   MS_PER_SEC   = 11'd1000;
  localparam logic [SEC_WIDTH:0]  SEC_PER_MIN  = 7'd60;
  localparam logic [MIN_WIDTH:0]  MIN_PER_HOUR = 7'd60;
  localparam logic [HOUR_WIDTH:0] HOUR_PER_DAY = 6'd24;

  // Month numbers that need special handling.
  localparam logic [MONTH_WIDTH-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_WIDTH-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_WIDTH-1:0] MONTH_DEC = 4'd12;

  // Day written when a month rolls over.
  localparam logic [DAY_WIDTH-1:0] FIRST_DAY = 5'd1;

  // Operation carried by each input item.
  typedef enum logic {
    OP_ADVANCE = 1'b0,
    OP_LOAD    = 1'b1
  } cta_op_e;

  // Input item.
  typedef struct packed {
    cta_op_e                     op;
    logic [MS_WIDTH-1:0]         add_ms;
    logic [YEAR_FIELD_WIDTH-1:0] load_year;
    logic [MONTH_WIDTH-1:0]      load_month;
    logic [DAY_WIDTH-1:0]        load_day;
    logic [HOUR_WIDTH-1:0]       load_hour;
    logic [MIN_WIDTH-1:0]        load_minute;
    logic [SEC_WIDTH-1:0]        load_second;
    logic [MS_WIDTH-1:0]         load_millisecond;
  } cta_in_t;

  // Result item.
  typedef struct packed {
    logic [YEAR_FIELD_WIDTH-1:0] out_year;
    logic [MONTH_WIDTH-1:0]      out_month;
    logic [DAY_WIDTH-1:0]        out_day;
    logic [HOUR_WIDTH-1:0]       out_hour;
    logic [MIN_WIDTH-1:0]        out_minute;
    logic [SEC_WIDTH-1:0]        out_second;
    logic [MS_WIDTH-1:0]         out_millisecond;
  } cta_out_t;

  // Time of day within one day.
  typedef struct packed {
    logic [HOUR_WIDTH-1:0] hour;
    logic [MIN_WIDTH-1:0]  minute;
    logic [SEC_WIDTH-1:0]  second;
    logic [MS_WIDTH-1:0]   millisecond;
  } cta_tod_t;

  // Time of day after an advance, plus the carry into the day count.
  typedef struct packed {
    cta_tod_t tod;
    logic     day_carry;
  } cta_tod_res_t;

  // True when the incremented day lies past the end of the month.
  // Months outside 1 to 12 never end.
  function automatic logic month_ended(input logic                   leap,
                                       input logic [MONTH_WIDTH-1:0] month,
                                       input logic [DAY_WIDTH:0]     day);
    logic [DAY_WIDTH:0] last;
    logic               known;
    last  = 6'd31;
    known = 1'b1;
    unique case (month) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: last = 6'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    last = 6'd30;
      MONTH_FEB:                                  last = leap ? 6'd29 : 6'd28;
      default:                                    known = 1'b0;
    endcase
    return known && (day > last);
  endfunction

endpackage

/* sv/cta_clock.sv */
// Time-of-day carry logic of the calendar timestamp advance unit.
// Adds a 10-bit millisecond count with a single carry and ripples the carry up to the day.
// Depends on cta_pkg.
module cta_clock (
  input  cta_pkg::cta_tod_t                  cur_i,
  input  logic [cta_pkg::MS_WIDTH-1:0]       add_ms_i,
  output cta_pkg::cta_tod_res_t              nxt_o
);
  import cta_pkg::*;

  logic [MS_WIDTH:0]   ms_sum;
  logic [MS_WIDTH:0]   ms_wrap;
  logic                ms_carry;
  logic [SEC_WIDTH:0]  sec_inc;
  logic                sec_carry;
  logic [MIN_WIDTH:0]  min_inc;
  logic                min_carry;
  logic [HOUR_WIDTH:0] hour_inc;
  logic                hour_carry;

  // Millisecond add with a single subtract of one second.
  always_comb begin
    ms_sum   = {1'b0, cur_i.millisecond} + {1'b0, add_ms_i};
    ms_carry = (ms_sum >= MS_PER_SEC);
    ms_wrap  = ms_carry ? (ms_sum - MS_PER_SEC) : ms_sum;
  end

  // Each unit carries at its modulus and loses exactly one modulus.
  always_comb begin
    sec_inc    = {1'b0, cur_i.second} + 7'd1;
    sec_carry  = ms_carry && (sec_inc >= SEC_PER_MIN);
    min_inc    = {1'b0, cur_i.minute} + 7'd1;
    min_carry  = sec_carry && (min_inc >= MIN_PER_HOUR);
    hour_inc   = {1'b0, cur_i.hour} + 6'd1;
    hour_carry = min_carry && (hour_inc >= HOUR_PER_DAY);
  end

  // Select the new value of each unit.
  always_comb begin
    nxt_o.tod.millisecond = ms_wrap[MS_WIDTH-1:0];

    if (!ms_carry) begin
      nxt_o.tod.second = cur_i.second;
    end else if (sec_carry) begin
      nxt_o.tod.second = SEC_WIDTH'(sec_inc - SEC_PER_MIN);
    end else begin
      nxt_o.tod.second = sec_inc[SEC_WIDTH-1:0];
    end

    if (!sec_carry) begin
      nxt_o.tod.minute = cur_i.minute;
    end else if (min_carry) begin
      nxt_o.tod.minute = MIN_WIDTH'(min_inc - MIN_PER_HOUR);
    end else begin
      nxt_o.tod.minute = min_inc[MIN_WIDTH-1:0];
    end

    if (!min_carry) begin
      nxt_o.tod.hour = cur_i.hour;
    end else if (hour_carry) begin
      nxt_o.tod.hour = HOUR_WIDTH'(hour_inc - HOUR_PER_DAY);
    end else begin
      nxt_o.tod.hour = hour_inc[HOUR_WIDTH-1:0];
    end

    nxt_o.day_carry = hour_carry;
  end

endmodule

/* sv/cta_date.sv */
// Date carry logic of the calendar timestamp advance unit.
// Steps day, month and year on a carry out of the time of day.
// Depends on cta_pkg.
module cta_date #(
  parameter int unsigned YEAR_WIDTH = cta_pkg::YEAR_WIDTH_DEF
) (
  input  logic [YEAR_WIDTH-1:0]             year_i,
  input  logic [cta_pkg::MONTH_WIDTH-1:0]   month_i,
  input  logic [cta_pkg::DAY_WIDTH-1:0]     day_i,
  input  logic                              day_carry_i,
  output logic [YEAR_WIDTH-1:0]             year_o,
  output logic [cta_pkg::MONTH_WIDTH-1:0]   month_o,
  output logic [cta_pkg::DAY_WIDTH-1:0]     day_o
);
  import cta_pkg::*;

  logic [DAY_WIDTH:0] day_inc;
  logic               leap;
  logic               ended;
  logic               year_end;

  // Month length check on the incremented day.
  always_comb begin
    day_inc  = {1'b0, day_i} + 6'd1;
    leap     = (year_i[1:0] == 2'b00);
    ended    = day_carry_i && month_ended(leap, month_i, day_inc);
    year_end = ended && (month_i == MONTH_DEC);
  end

  // New date. A day past 31 in a month that never ends wraps at five bits.
  always_comb begin
    year_o  = year_i;
    month_o = month_i;
    day_o   = day_i;
    if (year_end) begin
      day_o   = FIRST_DAY;
      month_o = MONTH_JAN;
      year_o  = year_i + YEAR_WIDTH'(1);
    end else if (ended) begin
      day_o   = FIRST_DAY;
      month_o = month_i + MONTH_WIDTH'(1);
    end else if (day_carry_i) begin
      day_o   = day_inc[DAY_WIDTH-1:0];
    end
  end

endmodule

/* sv/calendar_timestamp_advance_unit.sv */
// Top level of the calendar timestamp advance unit.
// Holds the input register, the timestamp state and the result register.
// Depends on cta_pkg, cta_clock and cta_date.
//
// The unit keeps a calendar timestamp and, for each input item, either loads
// a whole new timestamp or advances the current one by 0 to 1023 ms, carrying
// through seconds, minutes, hours, days, months and years (February has 29
// days when the year is divisible by 4). Every item yields one result item,
// the timestamp after that step. An item is registered on entry and its
// result is registered on exit, with a stall possible between the two, and
// one item is taken per cycle while the output is not stalled; the rate is
// set by the combinational carry path between the input register and the
// timestamp state. The year is kept YEAR_WIDTH bits wide and wraps there;
// the year field of a result carries its low 12 bits.
// After reset the timestamp is all zeros.
module calendar_timestamp_advance_unit #(
  parameter int unsigned YEAR_WIDTH = cta_pkg::YEAR_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cta_pkg::cta_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cta_pkg::cta_out_t out_data_o
);
  import cta_pkg::*;

  // Handshake and pipeline control.
  logic     in_vld_q, in_vld_d;
  logic     out_vld_q, out_vld_d;
  logic     out_free;
  logic     step;
  logic     in_acc;
  cta_in_t  in_q;
  cta_out_t out_q, out_d;

  // Timestamp state.
  logic [YEAR_WIDTH-1:0]  year_q, year_d;
  logic [MONTH_WIDTH-1:0] month_q, month_d;
  logic [DAY_WIDTH-1:0]   day_q, day_d;
  cta_tod_t               tod_q, tod_d;

  // Advance results.
  cta_tod_res_t           clk_nxt;
  logic [YEAR_WIDTH-1:0]  adv_year;
  logic [MONTH_WIDTH-1:0] adv_month;
  logic [DAY_WIDTH-1:0]   adv_day;

  // The output stage takes a new item when empty or being drained.
  always_comb begin
    out_free   = !out_vld_q || !out_stall_i;
    step       = in_vld_q && out_free;
    in_stall_o = in_vld_q && !out_free;
    in_acc     = in_valid_i && !in_stall_o;
  end

  // Valid bits of the input and output registers.
  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Input item register.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
  end

  // Time-of-day carry chain.
  cta_clock u_clock (
    .cur_i    (tod_q),
    .add_ms_i (in_q.add_ms),
    .nxt_o    (clk_nxt)
  );

  // Day, month and year carry.
  cta_date #(
    .YEAR_WIDTH (YEAR_WIDTH)
  ) u_date (
    .year_i      (year_q),
    .month_i     (month_q),
    .day_i       (day_q),
    .day_carry_i (clk_nxt.day_carry),
    .year_o      (adv_year),
    .month_o     (adv_month),
    .day_o       (adv_day)
  );

  // Next timestamp: either the loaded fields or the advanced one.
  always_comb begin
    if (in_q.op == OP_LOAD) begin
      year_d            = YEAR_WIDTH'(in_q.load_year);
      month_d           = in_q.load_month;
      day_d             = in_q.load_day;
      tod_d.hour        = in_q.load_hour;
      tod_d.minute      = in_q.load_minute;
      tod_d.second      = in_q.load_second;
      tod_d.millisecond = in_q.load_millisecond;
    end else begin
      year_d  = adv_year;
      month_d = adv_month;
      day_d   = adv_day;
      tod_d   = clk_nxt.tod;
    end
  end

  // The result item is the timestamp after the step.
  always_comb begin
    out_d.out_year        = YEAR_FIELD_WIDTH'(year_d);
    out_d.out_month       = month_d;
    out_d.out_day         = day_d;
    out_d.out_hour        = tod_d.hour;
    out_d.out_minute      = tod_d.minute;
    out_d.out_second      = tod_d.second;
    out_d.out_millisecond = tod_d.millisecond;
  end

  // Timestamp state, updated once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q  <= '0;
      month_q <= '0;
      day_q   <= '0;
      tod_q   <= '0;
    end else if (step) begin
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
      tod_q   <= tod_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // A fresh result matches the updated timestamp state in year, month, day and millisecond.
  a_result_matches_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> (out_data_o.out_year == YEAR_FIELD_WIDTH'(year_q)) &&
             (out_data_o.out_month == month_q) && (out_data_o.out_day == day_q) &&
             (out_data_o.out_millisecond == tod_q.millisecond))
    else $error("result item differs from the timestamp state");

  // A load item shows its own millisecond and second fields in the result.
  a_load_passes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && (in_q.op == OP_LOAD)) |=>
      (out_data_o.out_millisecond == $past(in_q.load_millisecond)) &&
      (out_data_o.out_second == $past(in_q.load_second)))
    else $error("loaded item not reflected in the result");

  // The input side stalls only behind a full, stalled output stage.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_vld_q && out_stall_i))
    else $error("input stalled without a blocked output");

endmodule
